// File: hdl/assert_macros.svh
// ============================================================================
// assertion macros
// clocked property checks with reset disable, used by deadline_drop_packet_queue
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// File: hdl/ddpq_pkg.sv
// ============================================================================
// ddpq_pkg
// types and constants of the deadline drop packet queue
// ============================================================================
package ddpq_pkg;

  localparam int STAMP_W = 32;
  localparam int COUNT_W = 20;
  localparam int TOTAL_W = 32;

  localparam int RUN_DEPTH_DEFAULT = 64;

  localparam logic [STAMP_W-1:0] DEADLINE_RESET  = 32'd30;
  localparam logic [COUNT_W-1:0] MAX_BATCH_RESET = 20'd1000000;

  // request opcodes
  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_SERVICE = 1'b1;

  // configuration register indexes
  localparam logic CFG_DEADLINE  = 1'b0;
  localparam logic CFG_MAX_BATCH = 1'b1;

  typedef struct packed {
    logic               op;
    logic [STAMP_W-1:0] now_time;
    logic [COUNT_W-1:0] batch_count;
    logic               success;
  } ddpq_in_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] dropped_now;
    logic               sent;
    logic               overflow;
    logic [TOTAL_W-1:0] queue_packets;
    logic [TOTAL_W-1:0] dropped_total;
    logic [TOTAL_W-1:0] sent_total;
  } ddpq_out_t;

endpackage

// File: hdl/ddpq_run_ram.sv
// ============================================================================
// ddpq_run_ram
// run ring storage: one write port, one read port with registered read data
// ============================================================================
module ddpq_run_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 52
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/deadline_drop_packet_queue.sv
// ============================================================================
// deadline_drop_packet_queue
// packet queue of (stamp, count) runs that drops runs past their deadline
// ============================================================================
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  in       | in_valid, in_ready, in_data      | request in
//  out      | out_valid, out_ready, out_data   | result out
//  cfg      | cfg_we, cfg_index, cfg_data      | register write
//
//  batch arrival: accept, ring update, result load
//  service slot: accept, ring read, age check, result load; each expired head
//    run repeats the ring read (one registered read) and the age compare
//  in_ready is high only while the sequencer is idle
//  a result waits in the output register; a stalled output holds the
//    sequencer at result load until the register frees
//  synchronous reset clears pointers, counts and out_valid; no clearing pass
// ============================================================================
`include "assert_macros.svh"

module deadline_drop_packet_queue #(
  parameter int RUN_DEPTH = ddpq_pkg::RUN_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ddpq_pkg::ddpq_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ddpq_pkg::ddpq_out_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data
);

  import ddpq_pkg::*;

  localparam int IW = $clog2(RUN_DEPTH);
  localparam int CW = $clog2(RUN_DEPTH + 1);
  localparam int DW = STAMP_W + COUNT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ARRIVE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_sub(input logic [TOTAL_W-1:0] a,
                                                 input logic [TOTAL_W-1:0] b);
    return (b > a) ? '0 : a - b;
  endfunction

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
    return (idx == IW'(RUN_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  logic [2:0]         state;
  logic [STAMP_W-1:0] deadline;
  logic [COUNT_W-1:0] max_batch;
  ddpq_in_t           req;

  logic [IW-1:0]      head_index;
  logic [IW-1:0]      tail_index;
  logic [CW-1:0]      runs_used;
  logic [TOTAL_W-1:0] waiting_packets;
  logic [TOTAL_W-1:0] drop_count;
  logic [TOTAL_W-1:0] send_count;

  logic [TOTAL_W-1:0] dropped;
  logic               sent;
  logic               overflow;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [DW-1:0]      ram_wdata;
  logic [DW-1:0]      ram_rdata;

  logic [STAMP_W-1:0] head_stamp;
  logic [COUNT_W-1:0] head_left;
  logic [COUNT_W-1:0] left_dec;
  logic [STAMP_W-1:0] age;
  logic               ring_empty;
  logic               ring_full;
  logic               expired;
  logic [COUNT_W-1:0] capped;
  logic [TOTAL_W-1:0] drop_count_next;
  logic               out_free;

  assign in_ready   = (state == S_IDLE) && !rst;
  assign head_stamp = ram_rdata[DW-1:COUNT_W];
  assign head_left  = ram_rdata[COUNT_W-1:0];
  assign left_dec   = head_left - 1'b1;
  assign age        = req.now_time - head_stamp;
  assign ring_empty = (runs_used == '0);
  assign ring_full  = (runs_used == CW'(RUN_DEPTH));
  assign expired    = !ring_empty && (age > deadline);
  assign capped     = (req.batch_count > max_batch) ? max_batch : req.batch_count;
  assign drop_count_next = sat_add(drop_count, dropped);
  assign out_free   = !out_valid || out_ready;

  // single write port: new run at the tail, or decremented head after a send
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_index;
    ram_wdata = {req.now_time, capped};
    case (state)
      S_ARRIVE: begin
        ram_we = (capped != '0) && !ring_full;
      end
      S_CHECK: begin
        ram_waddr = head_index;
        ram_wdata = {head_stamp, left_dec};
        ram_we    = !expired && !ring_empty && req.success;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ddpq_run_ram #(
    .DEPTH (RUN_DEPTH),
    .AW    (IW),
    .DW    (DW)
  ) u_run_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_index),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      deadline  <= DEADLINE_RESET;
      max_batch <= MAX_BATCH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEADLINE:  deadline  <= cfg_data;
        CFG_MAX_BATCH: max_batch <= cfg_data[COUNT_W-1:0];
        default:       deadline  <= deadline;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      head_index      <= '0;
      tail_index      <= '0;
      runs_used       <= '0;
      waiting_packets <= '0;
      drop_count      <= '0;
      send_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req      <= in_data;
            dropped  <= '0;
            sent     <= 1'b0;
            overflow <= 1'b0;
            state    <= (in_data.op == OP_ARRIVAL) ? S_ARRIVE : S_READ;
          end
        end
        S_ARRIVE: begin
          if (capped != '0) begin
            if (ring_full) begin
              dropped  <= TOTAL_W'(capped);
              overflow <= 1'b1;
            end else begin
              tail_index      <= ring_next(tail_index);
              runs_used       <= runs_used + 1'b1;
              waiting_packets <= sat_add(waiting_packets, TOTAL_W'(capped));
            end
          end
          state <= S_FINISH;
        end
        S_READ: begin
          // head entry lands in the read register
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (expired) begin
            dropped         <= sat_add(dropped, TOTAL_W'(head_left));
            waiting_packets <= sat_sub(waiting_packets, TOTAL_W'(head_left));
            head_index      <= ring_next(head_index);
            runs_used       <= runs_used - 1'b1;
            state           <= S_READ;
          end else begin
            if (!ring_empty && req.success) begin
              sent            <= 1'b1;
              send_count      <= sat_add(send_count, TOTAL_W'(1));
              waiting_packets <= sat_sub(waiting_packets, TOTAL_W'(1));
              if (left_dec == '0) begin
                head_index <= ring_next(head_index);
                runs_used  <= runs_used - 1'b1;
              end
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            drop_count             <= drop_count_next;
            out_data.dropped_now   <= dropped;
            out_data.sent          <= sent;
            out_data.overflow      <= overflow;
            out_data.queue_packets <= waiting_packets;
            out_data.dropped_total <= drop_count_next;
            out_data.sent_total    <= send_count;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_runs_bound, clk, rst, runs_used > CW'(RUN_DEPTH), "run count above ring depth")
  `ASSERT_CLK(a_ptr_match, clk, rst, (head_index == tail_index) |-> (ring_empty || ring_full), "pointers equal with partial ring")
  `ASSERT_CLK(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready, "sequencer idle right after accept")
  `ASSERT_NEVER(a_sent_and_ovf, clk, rst, out_valid && out_data.sent && out_data.overflow, "result both sent and overflow")

endmodule

// File: bench/tb.sv
// ============================================================================
// tb
// deadline drop packet queue bench: directed events, random request bursts, stalled results,
// checked against a predictor with its own run ring and counters
// ============================================================================
`timescale 1ns / 1ps

module tb;
  import ddpq_pkg::*;

  localparam int RUNS = RUN_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTS = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  ddpq_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ddpq_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  deadline_drop_packet_queue dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state: its own ring of (stamp, count) runs and the totals
  logic [STAMP_W-1:0] ring_stamp [RUNS];
  logic [COUNT_W-1:0] ring_count [RUNS];
  int                 ring_head = 0;
  int                 ring_tail = 0;
  int                 ring_used = 0;
  logic [TOTAL_W-1:0] queued_pkts = '0;
  logic [TOTAL_W-1:0] drop_total = '0;
  logic [TOTAL_W-1:0] send_total = '0;
  logic [STAMP_W-1:0] deadline_reg = DEADLINE_RESET;
  logic [COUNT_W-1:0] max_batch_reg = MAX_BATCH_RESET;

  ddpq_in_t  event_backlog [$];
  ddpq_out_t report_queue [$];
  ddpq_out_t want;

  logic [STAMP_W-1:0] stim_clock = '0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mon_cycle = 0;
  int results_seen = 0;
  int mismatches = 0;
  int n_arrivals = 0;
  int n_services = 0;
  int n_refused = 0;
  int n_expired = 0;
  int n_sent = 0;

  logic [31:0] phase_deadline [7] = '{32'd0, 32'hFFFF_FFFF, 32'd10, 32'd100,
                                      32'hFFFF_FFFF, 32'd1, 32'd0};
  logic [19:0] phase_batch [7] = '{20'hF_FFFF, 20'd0, 20'd5, 20'd1000,
                                   20'd3, 20'd1, 20'd0};

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] sat_sub(logic [31:0] a, logic [31:0] b);
    return (b > a) ? 32'd0 : a - b;
  endfunction

  function automatic void pop_run();
    ring_head = (ring_head + 1) % RUNS;
    ring_used--;
  endfunction

  // one queue event: returns the report it must produce
  function automatic ddpq_out_t apply_event(ddpq_in_t ev);
    ddpq_out_t          rep;
    logic [COUNT_W-1:0] cnt;
    logic [STAMP_W-1:0] age;
    logic               expiring;
    rep = '0;
    if (ev.op == OP_ARRIVAL) begin
      n_arrivals++;
      cnt = (ev.batch_count > max_batch_reg) ? max_batch_reg : ev.batch_count;
      if (cnt != '0) begin
        if (ring_used >= RUNS) begin
          rep.dropped_now = TOTAL_W'(cnt);
          rep.overflow = 1'b1;
          n_refused++;
        end else begin
          ring_stamp[ring_tail] = ev.now_time;
          ring_count[ring_tail] = cnt;
          ring_tail = (ring_tail + 1) % RUNS;
          ring_used++;
          queued_pkts = sat_add(queued_pkts, TOTAL_W'(cnt));
        end
      end
    end else begin
      n_services++;
      expiring = 1'b1;
      while (expiring) begin
        if (ring_used == 0) begin
          expiring = 1'b0;
        end else begin
          // age wraps modulo 2^32; a run exactly deadline old stays
          age = ev.now_time - ring_stamp[ring_head];
          if (age <= deadline_reg) begin
            expiring = 1'b0;
          end else begin
            rep.dropped_now = sat_add(rep.dropped_now, TOTAL_W'(ring_count[ring_head]));
            queued_pkts = sat_sub(queued_pkts, TOTAL_W'(ring_count[ring_head]));
            pop_run();
            n_expired++;
          end
        end
      end
      if (ring_used > 0 && ev.success) begin
        ring_count[ring_head] = ring_count[ring_head] - 1'b1;
        queued_pkts = sat_sub(queued_pkts, 32'd1);
        if (ring_count[ring_head] == '0) pop_run();
        rep.sent = 1'b1;
        send_total = sat_add(send_total, 32'd1);
        n_sent++;
      end
    end
    drop_total = sat_add(drop_total, rep.dropped_now);
    rep.queue_packets = queued_pkts;
    rep.dropped_total = drop_total;
    rep.sent_total = send_total;
    return rep;
  endfunction

  function automatic void push_event(logic op, logic [31:0] t, logic [19:0] cnt,
                                     logic ok);
    ddpq_in_t ev;
    ev.op = op;
    ev.now_time = t;
    ev.batch_count = cnt;
    ev.success = ok;
    event_backlog.insert(event_backlog.size(), ev);
  endfunction

  // mode 0 fills the ring, mode 1 drains it, anything else is balanced
  function automatic ddpq_in_t rand_event(int mode);
    ddpq_in_t    ev;
    logic [31:0] span;
    int          thr;
    span = (deadline_reg > 32'd4000) ? 32'd1000 : deadline_reg / 4 + 2;
    case ($urandom_range(0, 19))
      0:       stim_clock = stim_clock - $urandom_range(1, 40);
      1:       stim_clock = stim_clock + $urandom;
      2, 3:    stim_clock = stim_clock + deadline_reg + $urandom_range(1, 3);
      default: stim_clock = stim_clock + $urandom_range(0, span);
    endcase
    case (mode)
      0:       thr = 80;
      1:       thr = 25;
      default: thr = 50;
    endcase
    ev.op = ($urandom_range(0, 99) < thr) ? OP_ARRIVAL : OP_SERVICE;
    ev.now_time = stim_clock;
    case ($urandom_range(0, 9))
      0:       ev.batch_count = '0;
      1:       ev.batch_count = COUNT_W'($urandom);
      2:       ev.batch_count = '1;
      default: ev.batch_count = COUNT_W'($urandom_range(1, 4));
    endcase
    ev.success = ($urandom_range(0, 3) != 0);
    return ev;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v,
                                      logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  task automatic wait_idle();
    while (event_backlog.size() != 0 || report_queue.size() != 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEADLINE) deadline_reg = val;
    else max_batch_reg = val[COUNT_W-1:0];
  endtask

  task automatic run_random(int n);
    int mode;
    mode = 2;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) mode = $urandom_range(0, 2);
      event_backlog.insert(event_backlog.size(), rand_event(mode));
    end
    wait_idle();
  endtask

  // request driver: bursts of random length with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        report_queue.insert(report_queue.size(), apply_event(in_data));
        event_backlog.delete(0);
      end
      if (in_valid && !in_ready) begin
        // request still offered, payload held
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (event_backlog.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= event_backlog[0];
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor with its own stall pattern and two long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      mon_cycle++;
      if (out_valid && out_ready) begin
        results_seen++;
        if (report_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_PRINTS)
            $display("%0t: result expected none, actual %h", $time, out_data);
        end else begin
          want = report_queue[0];
          report_queue.delete(0);
          check_field("dropped_now", want.dropped_now, out_data.dropped_now);
          check_field("sent", 32'(want.sent), 32'(out_data.sent));
          check_field("overflow", 32'(want.overflow), 32'(out_data.overflow));
          check_field("queue_packets", want.queue_packets, out_data.queue_packets);
          check_field("dropped_total", want.dropped_total, out_data.dropped_total);
          check_field("sent_total", want.sent_total, out_data.sent_total);
        end
        if (results_seen == 150 || results_seen == 1200) hold_left = 400;
      end
      if (mon_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          2:       out_ready <= (mon_cycle % 4 == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed events at the reset settings (deadline 30)
    push_event(OP_SERVICE, 32'd0, 20'd0, 1'b1);          // empty queue
    push_event(OP_ARRIVAL, 32'd0, 20'd0, 1'b0);          // zero-size batch
    push_event(OP_ARRIVAL, 32'd1, 20'hF_FFFF, 1'b1);     // capped at max_batch
    push_event(OP_ARRIVAL, 32'd1, 20'd3, 1'b0);          // same stamp, own run
    push_event(OP_SERVICE, 32'd5, 20'hF_FFFF, 1'b0);     // no success
    push_event(OP_SERVICE, 32'd31, 20'd0, 1'b1);         // age equals deadline
    push_event(OP_SERVICE, 32'd32, 20'd0, 1'b1);         // both runs expire
    push_event(OP_ARRIVAL, 32'd40, 20'd2, 1'b0);
    push_event(OP_SERVICE, 32'd20, 20'd0, 1'b1);         // time goes backwards
    push_event(OP_ARRIVAL, 32'd40, 20'd1, 1'b1);
    push_event(OP_SERVICE, 32'd70, 20'd0, 1'b1);         // last packet of a run
    push_event(OP_ARRIVAL, 32'hFFFF_FFF0, 20'd1, 1'b0);
    push_event(OP_SERVICE, 32'd5, 20'd0, 1'b1);          // age across the wrap
    push_event(OP_ARRIVAL, 32'hFFFF_FFFF, 20'd2, 1'b1);
    push_event(OP_SERVICE, 32'h1F, 20'd0, 1'b0);         // expires across the wrap
    push_event(OP_ARRIVAL, 32'h1F, 20'd1000000, 1'b0);
    push_event(OP_ARRIVAL, 32'h20, 20'd1000001, 1'b1);
    push_event(OP_SERVICE, 32'h3E, 20'd0, 1'b1);
    push_event(OP_SERVICE, 32'h3E, 20'd0, 1'b1);
    stim_clock = 32'h40;
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      if (p == 6) begin
        phase_deadline[p] = $urandom_range(0, 200);
        phase_batch[p] = COUNT_W'($urandom_range(1, 64));
      end
      write_reg(CFG_DEADLINE, phase_deadline[p]);
      write_reg(CFG_MAX_BATCH, {12'd0, phase_batch[p]});
      run_random((p == 1) ? 40 : 270);
    end

    // fill the ring with the largest batches, then refuse a few more
    write_reg(CFG_DEADLINE, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_BATCH, 32'h000F_FFFF);
    for (int i = 0; i < RUNS; i++)
      push_event(OP_ARRIVAL, stim_clock, 20'hF_FFFF, 1'($urandom_range(0, 1)));
    push_event(OP_ARRIVAL, stim_clock, 20'd0, 1'b1);     // zero batch, full ring
    for (int i = 0; i < 24; i++)
      push_event(OP_ARRIVAL, stim_clock, 20'hF_FFFF, 1'($urandom_range(0, 1)));
    push_event(OP_SERVICE, stim_clock, 20'd0, 1'b1);
    wait_idle();
    write_reg(CFG_DEADLINE, 32'd0);
    push_event(OP_SERVICE, stim_clock + 32'd1, 20'd0, 1'b1);
    push_event(OP_SERVICE, stim_clock + 32'd2, 20'd0, 1'b1);
    wait_idle();

    $display("ran %0d batch arrivals and %0d service slots across a range of register settings",
             n_arrivals, n_services);
    $display("%0d batches refused on a full ring, %0d runs expired, %0d packets sent",
             n_refused, n_expired, n_sent);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/ddpq_pkg.sv
hdl/ddpq_run_ram.sv
hdl/deadline_drop_packet_queue.sv
bench/tb.sv
